[src/batch_norm_inference_assert.svh]
// Assertion macros for the batch normalisation block
`ifndef BATCH_NORM_INFERENCE_ASSERT_SVH
`define BATCH_NORM_INFERENCE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BNI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BNI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bni_pkg.sv]
// Types and constants shared by the batch normalisation block
package bni_pkg;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_VAR = 2'd1,
        STAT_SAT     = 2'd2
    } bni_status_t;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam int K_W   = 15;
    localparam int REM_W = 31;
    localparam int KV_W  = 23;
    localparam int CMP_W = 40;

    typedef struct packed {
        logic               kind;
        logic [5:0]         channel;
        logic signed [7:0]  x_value;
        logic signed [7:0]  scale_value;
        logic signed [7:0]  bias_value;
        logic signed [7:0]  mean_value;
        logic signed [7:0]  variance_value;
    } bni_in_t;

    typedef struct packed {
        logic signed [7:0]  y_value;
        bni_status_t        status;
    } bni_out_t;

    typedef struct packed {
        logic signed [7:0]  variance;
        logic signed [7:0]  mean;
        logic signed [7:0]  bias;
        logic signed [7:0]  scale;
    } bni_coef_t;

    // Word travelling down the square-root chain
    typedef struct packed {
        logic               kind;
        logic               bad;
        logic               neg;
        logic signed [7:0]  bias;
        logic [7:0]         v;
        logic [REM_W-1:0]   rem;
        logic [KV_W-1:0]    kv;
        logic [K_W-1:0]     k;
    } bni_lane_t;

endpackage

[src/bni_coef_mem.sv]
// Per-channel coefficient memory with registered read
module bni_coef_mem #(
    parameter int CHANNELS = 64
) (
    input  logic              aclk,
    input  logic              we_i,
    input  logic [5:0]        wr_chan_i,
    input  bni_pkg::bni_coef_t wr_data_i,
    input  logic              re_i,
    input  logic [5:0]        rd_chan_i,
    output bni_pkg::bni_coef_t rd_data_o
);
    import bni_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RED_W = 19;

    bni_coef_t mem [CHANNELS];
    bni_coef_t rd_data_reg;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    // Reduce a channel number modulo the table depth, one compare-subtract per bit
    function automatic logic [IDX_W-1:0] chan_mod(input logic [5:0] c);
        logic [RED_W-1:0] r;
        r = RED_W'(c);
        for (int j = 5; j >= 0; j--) begin
            if (r >= (RED_W'(CHANNELS) << j)) begin
                r = r - (RED_W'(CHANNELS) << j);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    assign wr_idx = chan_mod(wr_chan_i);
    assign rd_idx = chan_mod(rd_chan_i);

    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[wr_idx] <= wr_data_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (re_i) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data_o = rd_data_reg;

endmodule

[src/bni_sqrt_cell.sv]
// One cell of the square-root chain: decides one bit of floor(a / sqrt(v))
module bni_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en_i,
    input  logic               valid_i,
    input  bni_pkg::bni_lane_t lane_i,
    output logic               valid_o,
    output bni_pkg::bni_lane_t lane_o
);
    import bni_pkg::*;

    logic             valid_reg;
    bni_lane_t        lane_reg;
    bni_lane_t        lane_next;
    logic [CMP_W-1:0] delta;
    logic             take;

    // (k + 2^BIT)^2 * v - k^2 * v = k*v*2^(BIT+1) + v*2^(2*BIT)
    assign delta = (CMP_W'(lane_i.kv) << (BIT + 1)) + (CMP_W'(lane_i.v) << (2 * BIT));
    assign take  = delta <= CMP_W'(lane_i.rem);

    always_comb begin
        lane_next = lane_i;
        if (take) begin
            lane_next.rem = lane_i.rem - delta[REM_W-1:0];
            lane_next.kv  = lane_i.kv + (KV_W'(lane_i.v) << BIT);
            lane_next.k   = lane_i.k | (K_W'(1'b1) << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en_i) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            lane_reg <= lane_next;
        end
    end

    assign valid_o = valid_reg;
    assign lane_o  = lane_reg;

endmodule

[src/batch_norm_inference.sv]
// Int8 batch normalisation for inference, one element per cycle.
// Input channel s_valid/s_ready/s_data: kind 1 loads a channel's scale, bias,
// mean and variance; kind 0 normalises x_value against its channel's entry.
// Each word gives one result word on m_valid/m_ready/m_data: y_value and
// status (ok, variance plus epsilon not positive, saturated). Loads answer 0.
// Config channel cfg_valid/cfg_ready/cfg_data writes epsilon; cfg_ready is
// always high. Write it only while the block is empty.
// m_valid rises once a word has passed memory read, multiply, square,
// fifteen square-root cells and the output register.
// Throughput: one word per cycle while m_ready allows; each square-root cell
// settles one quotient bit, so chain length sets the latency and not the rate.
// Every stage holds its own valid bit and advances when the next one is free,
// so s_ready stays high while bubbles remain even if m_ready is low; a full
// pipeline holds when the receiver stalls and drops s_ready.
// Synchronous active-low reset empties the pipeline and sets epsilon to 1;
// the coefficient table is not cleared and must be loaded before use.
module batch_norm_inference #(
    parameter int CHANNELS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bni_pkg::bni_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bni_pkg::bni_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [7:0]  cfg_data
);
    import bni_pkg::*;

    `include "batch_norm_inference_assert.svh"

    localparam int NCELL = K_W;
    localparam int NSTG  = NCELL + 4;   // read, multiply, square, cells, output

    logic signed [7:0] eps_reg;
    logic [NSTG-1:0]   vld;
    logic [NSTG:0]     en;

    // stage 1: memory read
    logic              s1_vld_reg;
    logic              s1_kind_reg;
    logic signed [7:0] s1_x_reg;
    bni_coef_t         s1_coef;
    logic              accept;

    // stage 2: multiply
    logic                s2_vld_reg;
    logic                s2_kind_reg;
    logic                s2_bad_reg;
    logic signed [16:0]  s2_p_reg;
    logic [7:0]          s2_v_reg;
    logic signed [7:0]   s2_bias_reg;
    logic signed [8:0]   v_sum;
    logic signed [8:0]   diff;

    // stage 3: square
    logic                s3_vld_reg;
    bni_lane_t           lane0_reg;
    bni_lane_t           lane [NCELL+1];
    logic [NCELL:0]      lane_vld;
    logic [15:0]         abs_p;
    logic [31:0]         sq;

    // output
    bni_out_t            m_data_reg;
    bni_out_t            m_data_next;
    logic                m_valid_reg;
    logic signed [17:0]  k_ext;
    logic signed [17:0]  fl;
    logic signed [17:0]  fr;
    logic signed [17:0]  tr;
    logic                exact;
    bni_lane_t           lf;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= 8'sd1;
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    // Advance chain: a stage moves when empty or when its successor moves
    always_comb begin
        en[NSTG] = !m_valid_reg || m_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            en[i] = !vld[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign accept  = s_valid && s_ready;

    bni_coef_mem #(.CHANNELS(CHANNELS)) u_mem (
        .aclk      (aclk),
        .we_i      (accept && (s_data.kind == KIND_LOAD)),
        .wr_chan_i (s_data.channel),
        .wr_data_i ({s_data.variance_value, s_data.mean_value,
                     s_data.bias_value, s_data.scale_value}),
        .re_i      (en[0]),
        .rd_chan_i (s_data.channel),
        .rd_data_o (s1_coef)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            if (en[0]) s1_vld_reg <= accept;
            if (en[1]) s2_vld_reg <= s1_vld_reg;
            if (en[2]) s3_vld_reg <= s2_vld_reg;
        end
    end

    assign vld[0] = s1_vld_reg;
    assign vld[1] = s2_vld_reg;
    assign vld[2] = s3_vld_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_kind_reg <= s_data.kind;
            s1_x_reg    <= s_data.x_value;
        end
    end

    assign v_sum = 9'(s1_coef.variance) + 9'(eps_reg);
    assign diff  = 9'(s1_x_reg) - 9'(s1_coef.mean);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_kind_reg <= s1_kind_reg;
            s2_bad_reg  <= v_sum <= 9'sd0;
            s2_v_reg    <= v_sum[7:0];
            s2_bias_reg <= s1_coef.bias;
            s2_p_reg    <= 17'(s1_coef.scale * diff);
        end
    end

    assign abs_p = s2_p_reg[16] ? 16'(-s2_p_reg) : s2_p_reg[15:0];
    assign sq    = abs_p * abs_p;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            lane0_reg.kind <= s2_kind_reg;
            lane0_reg.bad  <= s2_bad_reg;
            lane0_reg.neg  <= s2_p_reg[16];
            lane0_reg.bias <= s2_bias_reg;
            lane0_reg.v    <= s2_v_reg;
            lane0_reg.rem  <= sq[REM_W-1:0];
            lane0_reg.kv   <= '0;
            lane0_reg.k    <= '0;
        end
    end

    assign lane[0]     = lane0_reg;
    assign lane_vld[0] = vld[2];

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        bni_sqrt_cell #(.BIT(NCELL - 1 - g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en_i    (en[3+g]),
            .valid_i (lane_vld[g]),
            .lane_i  (lane[g]),
            .valid_o (lane_vld[g+1]),
            .lane_o  (lane[g+1])
        );
        assign vld[3+g] = lane_vld[g+1];
    end

    // Truncate toward zero and saturate
    assign lf    = lane[NCELL];
    assign exact = lf.rem == '0;
    assign k_ext = 18'(lf.k);

    always_comb begin
        fl = lf.neg ? (exact ? -k_ext : -k_ext - 18'sd1) : k_ext;
        fr = fl + 18'(lf.bias);
        tr = (fr < 18'sd0 && !exact) ? fr + 18'sd1 : fr;
        m_data_next.y_value = tr[7:0];
        m_data_next.status  = STAT_OK;
        if (lf.kind == KIND_LOAD) begin
            m_data_next.y_value = 8'sd0;
        end else if (lf.bad) begin
            m_data_next.y_value = 8'sd0;
            m_data_next.status  = STAT_BAD_VAR;
        end else if (tr > 18'sd127) begin
            m_data_next.y_value = 8'sd127;
            m_data_next.status  = STAT_SAT;
        end else if (tr < -18'sd128) begin
            m_data_next.y_value = -8'sd128;
            m_data_next.status  = STAT_SAT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en[NSTG]) begin
            m_valid_reg <= vld[NSTG-2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NSTG]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign vld[NSTG-1] = m_valid_reg;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    `BNI_ASSERT_IMP(a_bad_var_zero, m_valid && (m_data.status == STAT_BAD_VAR),
        m_data.y_value == 8'sd0, "bad variance result not zero")
    `BNI_ASSERT_IMP(a_sat_bound, m_valid && (m_data.status == STAT_SAT),
        (m_data.y_value == 8'sd127) || (m_data.y_value == -8'sd128), "saturation off bound")
    `BNI_ASSERT_NXT(a_accept_lands, s_valid && s_ready, vld[0], "accepted word lost")

endmodule
